// ----- sv/pwfd_pkg.sv -----
// Shared types and constants for the protobuf wire field decoder.
// No dependencies; imported by every module of the block.
package pwfd_pkg;

    localparam int KNOWN_FIELD_SLOTS_DEF = 64;
    localparam int LENGTH_BITS_DEF       = 32;

    localparam int TAG_MAX_BYTES    = 5;
    localparam int VARINT_MAX_BYTES = 10;

    // Result queue: four entries, two written per cycle at most.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    localparam int FIELD_NUM_W = 29;
    localparam int TDATA_W     = 104;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_SCALAR  = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNCATED = 3'd1,
        ERR_GROUP     = 3'd2,
        ERR_BAD_TYPE  = 3'd3,
        ERR_OVERLONG  = 3'd4,
        ERR_LEN_LARGE = 3'd5
    } err_t;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_SGROUP  = 3'd3;
    localparam logic [2:0] WT_EGROUP  = 3'd4;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    typedef struct packed {
        kind_t                  kind;
        logic [FIELD_NUM_W-1:0] field_num;
        logic [2:0]             wire_code;
        logic [63:0]            field_value;
        err_t                   error_code;
        logic                   last_of_run;
    } result_t;

    // Results produced by one input byte, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t make_result(kind_t k, logic [FIELD_NUM_W-1:0] fnum,
                                            logic [2:0] wt, logic [63:0] val, err_t e);
        result_t r;
        r.kind         = k;
        r.field_num    = fnum;
        r.wire_code    = wt;
        r.field_value  = val;
        r.error_code   = e;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

// ----- sv/pwfd_decode.sv -----
// Byte-level decode step: tag, varint, fixed and length/payload state with
// the known-field register. Depends on pwfd_pkg.
module pwfd_decode #(
    parameter int KNOWN_FIELD_SLOTS = pwfd_pkg::KNOWN_FIELD_SLOTS_DEF,
    parameter int LENGTH_BITS       = pwfd_pkg::LENGTH_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [63:0]     cfg_wr_data,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    input  logic            in_eom,
    output pwfd_pkg::push_t push
);
    import pwfd_pkg::*;

    localparam logic [63:0] LEN_LIMIT = (LENGTH_BITS >= 64) ? {64{1'b1}} :
                                        ((64'd1 << LENGTH_BITS) - 64'd1);

    logic [63:0]            known_fields_reg;
    phase_t                 phase_reg, phase_next;
    logic [63:0]            acc_reg, acc_next;
    logic [3:0]             idx_reg, idx_next;
    logic [FIELD_NUM_W-1:0] field_reg, field_next;
    logic [2:0]             wire_reg, wire_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic                   known_reg, known_next;
    logic                   discarding_reg, discarding_next;

    logic [6:0]  idx_x7;
    logic [5:0]  shamt;
    logic [63:0] shifted;
    logic [63:0] acc_or;

    always_comb begin
        idx_x7  = 7'({idx_reg, 3'b000}) - 7'(idx_reg);
        shamt   = (phase_reg == PH_FIXED) ? {idx_reg[2:0], 3'b000} : idx_x7[5:0];
        shifted = (phase_reg == PH_FIXED) ? ({56'd0, in_byte} << shamt)
                                          : ({57'd0, in_byte[6:0]} << shamt);
        acc_or  = acc_reg | shifted;
    end

    always_comb begin
        err_t                   err;
        logic [FIELD_NUM_W-1:0] ef;
        logic [2:0]             ew;
        logic                   vres_valid;
        result_t                vres;
        logic                   tail_valid;
        result_t                tail;
        logic [31:0]            tag;

        phase_next      = phase_reg;
        acc_next        = acc_reg;
        idx_next        = idx_reg;
        field_next      = field_reg;
        wire_next       = wire_reg;
        left_next       = left_reg;
        known_next      = known_reg;
        discarding_next = discarding_reg;
        err        = ERR_NONE;
        ef         = '0;
        ew         = '0;
        vres_valid = 1'b0;
        vres       = make_result(KIND_DONE, '0, '0, '0, ERR_NONE);
        tail_valid = 1'b0;
        tail       = make_result(KIND_DONE, '0, '0, '0, ERR_NONE);
        tag        = acc_or[31:0];

        if (in_fire && discarding_reg) begin
            if (in_eom) begin
                discarding_next = 1'b0;
                phase_next = PH_TAG;
                acc_next   = '0;
                idx_next   = '0;
                left_next  = '0;
            end
        end else if (in_fire) begin
            unique case (phase_reg)
                PH_VARINT, PH_LEN: begin
                    acc_next = acc_or;
                    ef = field_reg;
                    ew = wire_reg;
                    if (in_byte[7]) begin
                        idx_next = idx_reg + 4'd1;
                        if (idx_reg == 4'(VARINT_MAX_BYTES - 1)) begin
                            err = ERR_OVERLONG;
                        end
                    end else if (phase_reg == PH_VARINT) begin
                        vres_valid = known_reg;
                        vres = make_result(KIND_SCALAR, field_reg, wire_reg, acc_or, ERR_NONE);
                        phase_next = PH_TAG;
                        acc_next   = '0;
                        idx_next   = '0;
                        left_next  = '0;
                    end else if (acc_or > LEN_LIMIT) begin
                        err = ERR_LEN_LARGE;
                    end else begin
                        vres_valid = known_reg;
                        vres = make_result(KIND_HEADER, field_reg, wire_reg, acc_or, ERR_NONE);
                        phase_next = PH_TAG;
                        acc_next   = '0;
                        idx_next   = '0;
                        left_next  = '0;
                        // zero length: the field ends with its header
                        if (acc_or != 64'd0) begin
                            phase_next = PH_PAYLOAD;
                            left_next  = acc_or[LENGTH_BITS-1:0];
                        end
                    end
                end
                PH_FIXED: begin
                    acc_next = acc_or;
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg == ((wire_reg == WT_FIXED64) ? 4'd7 : 4'd3)) begin
                        vres_valid = known_reg;
                        vres = make_result(KIND_SCALAR, field_reg, wire_reg, acc_or, ERR_NONE);
                        phase_next = PH_TAG;
                        acc_next   = '0;
                        idx_next   = '0;
                        left_next  = '0;
                    end
                end
                PH_PAYLOAD: begin
                    vres_valid = known_reg;
                    vres = make_result(KIND_PAYLOAD, field_reg, wire_reg, {56'd0, in_byte},
                                       ERR_NONE);
                    if (left_reg <= LENGTH_BITS'(1)) begin
                        phase_next = PH_TAG;
                        acc_next   = '0;
                        idx_next   = '0;
                        left_next  = '0;
                    end else begin
                        left_next = left_reg - LENGTH_BITS'(1);
                    end
                end
                PH_TAG: begin
                    acc_next = acc_or;
                    if (in_byte[7]) begin
                        idx_next = idx_reg + 4'd1;
                        if (idx_reg == 4'(TAG_MAX_BYTES - 1)) begin
                            err = ERR_OVERLONG;
                        end
                    end else begin
                        wire_next  = tag[2:0];
                        field_next = tag[31:3];
                        known_next = ({3'b000, tag[31:3]} < 32'(KNOWN_FIELD_SLOTS)) &&
                                     known_fields_reg[tag[8:3]];
                        ef = tag[31:3];
                        ew = tag[2:0];
                        phase_next = PH_TAG;
                        acc_next   = '0;
                        idx_next   = '0;
                        left_next  = '0;
                        unique case (tag[2:0]) inside
                            WT_VARINT:             phase_next = PH_VARINT;
                            WT_FIXED64, WT_FIXED32: phase_next = PH_FIXED;
                            WT_LEN:                phase_next = PH_LEN;
                            WT_SGROUP, WT_EGROUP:  err = ERR_GROUP;
                            default:               err = ERR_BAD_TYPE;
                        endcase
                    end
                end
                default: begin
                    phase_next = PH_TAG;
                end
            endcase

            if (err != ERR_NONE) begin
                tail_valid = 1'b1;
                tail = make_result(KIND_ERROR, ef, ew, '0, err);
                phase_next = PH_TAG;
                acc_next   = '0;
                idx_next   = '0;
                left_next  = '0;
                discarding_next = !in_eom;
            end else if (in_eom) begin
                tail_valid = 1'b1;
                if (phase_next == PH_TAG && idx_next == 4'd0) begin
                    tail = make_result(KIND_DONE, '0, '0, '0, ERR_NONE);
                end else if (phase_next == PH_TAG) begin
                    tail = make_result(KIND_ERROR, '0, '0, '0, ERR_TRUNCATED);
                end else begin
                    tail = make_result(KIND_ERROR, field_next, wire_next, '0, ERR_TRUNCATED);
                end
                phase_next = PH_TAG;
                acc_next   = '0;
                idx_next   = '0;
                left_next  = '0;
            end
        end

        // order the value result ahead of the done/error result
        push.count  = 2'(vres_valid) + 2'(tail_valid);
        push.first  = vres_valid ? vres : tail;
        push.second = tail;
        if (vres_valid && tail_valid) begin
            push.second.last_of_run = 1'b1;
        end else begin
            push.first.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            known_fields_reg <= {64{1'b1}};
            phase_reg        <= PH_TAG;
            acc_reg          <= '0;
            idx_reg          <= '0;
            field_reg        <= '0;
            wire_reg         <= '0;
            left_reg         <= '0;
            known_reg        <= 1'b0;
            discarding_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                known_fields_reg <= cfg_wr_data;
            end
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            idx_reg        <= idx_next;
            field_reg      <= field_next;
            wire_reg       <= wire_next;
            left_reg       <= left_next;
            known_reg      <= known_next;
            discarding_reg <= discarding_next;
        end
    end

    a_discard_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && discarding_reg) |-> (push.count == 2'd0))
        else $error("result produced while discarding");

    a_error_starts_discard: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !discarding_reg && !in_eom && push.count != 2'd0 &&
         push.first.kind == KIND_ERROR) |=> discarding_reg)
        else $error("error mid-message did not start discard");

    a_eom_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_eom) |=> (phase_reg == PH_TAG && idx_reg == 4'd0 && !discarding_reg))
        else $error("end of message did not restart the decoder");

endmodule

// ----- sv/pwfd_result_fifo.sv -----
// Four-entry result queue: takes up to two results per cycle from the
// decode step, hands out one per cycle while out_ready is high. Depends on pwfd_pkg.
module pwfd_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  pwfd_pkg::push_t   push,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pwfd_pkg::result_t out_res
);
    import pwfd_pkg::*;

    result_t               entries_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RQ_CNT_W-1:0]   count_reg;
    logic                  pop;

    // room for a full two-result request, without looking at the pop
    assign in_ready  = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entries_reg[wr_ptr_reg + RQ_PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + RQ_PTR_W'(pop);
            count_reg  <= count_reg + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2)))
        else $error("result queue written without room");

    a_ptr_count_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[RQ_PTR_W-1:0])
        else $error("result queue pointers disagree with count");

endmodule

// ----- sv/protobuf_wire_field_decoder.sv -----
// Protobuf wire field decoder, top level: stream ports, decode step and result queue.
// Depends on pwfd_pkg, pwfd_decode and pwfd_result_fifo.
//
// Takes an encoded message one byte per clock on the s_ stream (tlast marks the
// last byte) and emits field results on the m_ stream: scalar values, length
// headers, one result per payload byte, a done mark per message, or one error
// after which the rest of the message is dropped. Each byte is decoded in the
// cycle it is accepted, so input runs at one byte per clock; a byte yields zero,
// one or two results, results leave at one per clock while m_tready is high, and
// s_tready drops only when the four-entry result queue holds more than two results.
// known_fields (cfg_wr_en/cfg_wr_data, reset all ones) selects which field numbers
// below KNOWN_FIELD_SLOTS are reported; others are parsed and skipped silently.
// Write it only while the block is idle.
module protobuf_wire_field_decoder #(
    parameter int KNOWN_FIELD_SLOTS = pwfd_pkg::KNOWN_FIELD_SLOTS_DEF,
    parameter int LENGTH_BITS       = pwfd_pkg::LENGTH_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [63:0]   cfg_wr_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] in_byte
    input  logic          s_tlast,   // end_of_message
    output logic          m_tvalid,
    input  logic          m_tready,
    // [28:0] field number, [31:29] wire type, [95:32] field_value,
    // [98:96] error_code, [103:99] zero
    output logic [pwfd_pkg::TDATA_W-1:0] m_tdata,
    output logic [2:0]    m_tuser,   // [2:0] kind
    output logic          m_tlast    // last_of_run
);
    import pwfd_pkg::*;

    push_t   push;
    result_t out_res;
    logic    in_fire;

    assign in_fire = s_tvalid && s_tready;

    pwfd_decode #(
        .KNOWN_FIELD_SLOTS (KNOWN_FIELD_SLOTS),
        .LENGTH_BITS       (LENGTH_BITS)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .in_eom      (s_tlast),
        .push        (push)
    );

    pwfd_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'd0, out_res.error_code, out_res.field_value,
                      out_res.wire_code, out_res.field_num};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_of_run;

endmodule
